### hdl/sdtp_pkg.sv
// ----------------------------------------------------------------------------
// sdtp_pkg
// Shared widths, character codes, token classes and the token type passed
// from the classifier to the number accumulator.
// ----------------------------------------------------------------------------
package sdtp_pkg;

	localparam int SIG_BITS        = 64;
	localparam int FRAC_COUNT_BITS = 16;
	localparam int EXP_BITS        = 14;
	localparam int EXP_MAX         = 9999;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] CLS_SPACE = 3'd0;
	localparam logic [2:0] CLS_SIGN  = 3'd1;
	localparam logic [2:0] CLS_DIGIT = 3'd2;
	localparam logic [2:0] CLS_POINT = 3'd3;
	localparam logic [2:0] CLS_EXP   = 3'd4;
	localparam logic [2:0] CLS_OTHER = 3'd5;

	typedef struct packed {
		logic [2:0] cls;
		logic       minus;
		logic [3:0] digit;
		logic       last;
	} tok_t;

endpackage

### hdl/scientific_decimal_text_parser.sv
// The last item passes the front register and token queue to the result register.
// Throughput: one character item per cycle, but a last item waits for a free result.
// The output register frees the input side while a result waits to be taken.
// Reset (arst_n low): clears the parse state, the token queue and all valid flags.
// ----------------------------------------------------------------------------
// scientific_decimal_text_parser
// Splits scientific-notation decimal text into sign, significand, fraction
// digit count and exponent: classifier, token queue, accumulator.
// ----------------------------------------------------------------------------
module scientific_decimal_text_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 char_code,
	input  logic                       last_char,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       negative,
	output logic [sdtp_pkg::SIG_BITS-1:0]        significand,
	output logic [sdtp_pkg::FRAC_COUNT_BITS-1:0] frac_digits,
	output logic                       exp_negative,
	output logic [sdtp_pkg::EXP_BITS-1:0]        exp_value,
	output logic                       overflow
);
	import sdtp_pkg::*;

	logic fr_valid;
	logic fr_ready;
	tok_t fr_tok;
	logic bk_valid;
	logic bk_ready;
	tok_t bk_tok;

	sdtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last_char (last_char),
		.tok_valid (fr_valid),
		.tok_ready (fr_ready),
		.tok       (fr_tok)
	);

	sdtp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_tok   (fr_tok),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_tok    (bk_tok)
	);

	sdtp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (bk_valid),
		.tok_ready    (bk_ready),
		.tok          (bk_tok),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.negative     (negative),
		.significand  (significand),
		.frac_digits  (frac_digits),
		.exp_negative (exp_negative),
		.exp_value    (exp_value),
		.overflow     (overflow)
	);

endmodule

### hdl/sdtp_front.sv
// ----------------------------------------------------------------------------
// sdtp_front
// Accepts characters, classifies each into a token and registers it for the
// token queue.
// ----------------------------------------------------------------------------
module sdtp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_code,
	input  logic          last_char,
	output logic          tok_valid,
	input  logic          tok_ready,
	output sdtp_pkg::tok_t tok
);
	import sdtp_pkg::*;

	logic valid_s1;
	tok_t tok_s1;
	tok_t tok_c;

	always_comb begin
		tok_c.minus = (char_code == CH_MINUS);
		tok_c.digit = char_code[3:0];
		tok_c.last  = last_char;
		if ((char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR))) begin
			tok_c.cls = CLS_SPACE;
		end else if ((char_code == CH_MINUS) || (char_code == CH_PLUS)) begin
			tok_c.cls = CLS_SIGN;
		end else if ((char_code >= CH_ZERO) && (char_code <= CH_NINE)) begin
			tok_c.cls = CLS_DIGIT;
		end else if (char_code == CH_POINT) begin
			tok_c.cls = CLS_POINT;
		end else if ((char_code == CH_E_LO) || (char_code == CH_E_UP)) begin
			tok_c.cls = CLS_EXP;
		end else begin
			tok_c.cls = CLS_OTHER;
		end
	end

	assign in_ready  = !valid_s1 || tok_ready;
	assign tok_valid = valid_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_s1 <= tok_c;
		end
	end

endmodule

### hdl/sdtp_queue.sv
// ----------------------------------------------------------------------------
// sdtp_queue
// Short token queue between classifier and accumulator.
// ----------------------------------------------------------------------------
module sdtp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sdtp_pkg::tok_t push_tok,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sdtp_pkg::tok_t pop_tok
);
	import sdtp_pkg::*;

	tok_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

endmodule

### hdl/sdtp_back.sv
// ----------------------------------------------------------------------------
// sdtp_back
// Number accumulator: runs the parse phases on each token, builds the
// significand, fraction count and exponent, and holds the result register.
// ----------------------------------------------------------------------------
module sdtp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tok_valid,
	output logic                       tok_ready,
	input  sdtp_pkg::tok_t             tok,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       negative,
	output logic [sdtp_pkg::SIG_BITS-1:0]        significand,
	output logic [sdtp_pkg::FRAC_COUNT_BITS-1:0] frac_digits,
	output logic                       exp_negative,
	output logic [sdtp_pkg::EXP_BITS-1:0]        exp_value,
	output logic                       overflow
);
	import sdtp_pkg::*;

	localparam logic [2:0] PH_WS    = 3'd0;
	localparam logic [2:0] PH_INT   = 3'd1;
	localparam logic [2:0] PH_FRAC  = 3'd2;
	localparam logic [2:0] PH_ESIGN = 3'd3;
	localparam logic [2:0] PH_EDIG  = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	localparam int SIG_W = SIG_BITS + 4;
	localparam int EXP_W = EXP_BITS + 4;

	logic [2:0]                 phase_q, phase_n;
	logic                       neg_q, neg_n;
	logic [SIG_BITS-1:0]        sig_q, sig_n;
	logic [FRAC_COUNT_BITS-1:0] frac_q, frac_n;
	logic                       eneg_q, eneg_n;
	logic [EXP_BITS-1:0]        exp_q, exp_n;
	logic                       sat_q, sat_n;
	logic                       out_valid_q;

	logic [SIG_W-1:0]           sig_x10;
	logic [EXP_W-1:0]           exp_x10;
	logic                       add_sig;
	logic                       add_exp;
	logic                       add_frac;
	logic                       pop;

	assign sig_x10 = ({4'b0, sig_q} << 3) + ({4'b0, sig_q} << 1) + SIG_W'(tok.digit);
	assign exp_x10 = ({4'b0, exp_q} << 3) + ({4'b0, exp_q} << 1) + EXP_W'(tok.digit);

	always_comb begin
		phase_n  = phase_q;
		neg_n    = neg_q;
		eneg_n   = eneg_q;
		add_sig  = 1'b0;
		add_exp  = 1'b0;
		add_frac = 1'b0;
		case (phase_q)
			PH_WS: begin
				case (tok.cls)
					CLS_SPACE: phase_n = PH_WS;
					CLS_SIGN: begin
						neg_n   = tok.minus;
						phase_n = PH_INT;
					end
					CLS_DIGIT: begin
						add_sig = 1'b1;
						phase_n = PH_INT;
					end
					CLS_POINT: phase_n = PH_FRAC;
					CLS_EXP:   phase_n = PH_ESIGN;
					default:   phase_n = PH_DONE;
				endcase
			end
			PH_INT: begin
				case (tok.cls)
					CLS_DIGIT: add_sig = 1'b1;
					CLS_POINT: phase_n = PH_FRAC;
					CLS_EXP:   phase_n = PH_ESIGN;
					default:   phase_n = PH_DONE;
				endcase
			end
			PH_FRAC: begin
				case (tok.cls)
					CLS_DIGIT: begin
						add_sig  = 1'b1;
						add_frac = 1'b1;
					end
					CLS_EXP: phase_n = PH_ESIGN;
					default: phase_n = PH_DONE;
				endcase
			end
			PH_ESIGN: begin
				case (tok.cls)
					CLS_SIGN: begin
						eneg_n  = tok.minus;
						phase_n = PH_EDIG;
					end
					CLS_DIGIT: begin
						add_exp = 1'b1;
						phase_n = PH_EDIG;
					end
					default: phase_n = PH_DONE;
				endcase
			end
			PH_EDIG: begin
				if (tok.cls == CLS_DIGIT) begin
					add_exp = 1'b1;
				end else begin
					phase_n = PH_DONE;
				end
			end
			default: phase_n = PH_DONE;
		endcase

		sig_n = sig_q;
		sat_n = sat_q;
		if (add_sig) begin
			if (sat_q || (sig_x10[SIG_W-1:SIG_BITS] != 4'b0)) begin
				sig_n = '1;
				sat_n = 1'b1;
			end else begin
				sig_n = sig_x10[SIG_BITS-1:0];
			end
		end

		frac_n = frac_q;
		if (add_frac && (frac_q != '1)) begin
			frac_n = frac_q + 1'b1;
		end

		exp_n = exp_q;
		if (add_exp) begin
			if (exp_x10 > EXP_W'(EXP_MAX)) begin
				exp_n = EXP_BITS'(EXP_MAX);
			end else begin
				exp_n = exp_x10[EXP_BITS-1:0];
			end
		end
	end

	// last item of a string needs a free result slot
	assign tok_ready = !tok.last || !out_valid_q || out_ready;
	assign pop       = tok_valid && tok_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WS;
			neg_q       <= 1'b0;
			sig_q       <= '0;
			frac_q      <= '0;
			eneg_q      <= 1'b0;
			exp_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (tok.last) begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_WS;
					neg_q       <= 1'b0;
					sig_q       <= '0;
					frac_q      <= '0;
					eneg_q      <= 1'b0;
					exp_q       <= '0;
					sat_q       <= 1'b0;
				end else begin
					phase_q <= phase_n;
					neg_q   <= neg_n;
					sig_q   <= sig_n;
					frac_q  <= frac_n;
					eneg_q  <= eneg_n;
					exp_q   <= exp_n;
					sat_q   <= sat_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			negative     <= neg_n;
			significand  <= sig_n;
			frac_digits  <= frac_n;
			exp_negative <= eneg_n;
			exp_value    <= exp_n;
			overflow     <= sat_n;
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams number text into the parser one character item at a time and
// checks each string's split fields against an in-bench parse of the same
// characters, with random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_top;
	import sdtp_pkg::*;

	typedef enum logic [2:0] {
		SCAN_WS, SCAN_INT, SCAN_FRAC, SCAN_ESIGN, SCAN_EDIG, SCAN_DONE
	} scan_phase_t;

	typedef struct {
		logic                       neg;
		logic [SIG_BITS-1:0]        sig;
		logic [FRAC_COUNT_BITS-1:0] frac;
		logic                       eneg;
		logic [EXP_BITS-1:0]        eval;
		logic                       ovf;
	} num_fields_t;

	typedef struct {
		logic [7:0]  code;
		logic        last;
		int unsigned gap;
	} char_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_code = 8'h00;
	logic last_char = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic negative;
	logic [SIG_BITS-1:0] significand;
	logic [FRAC_COUNT_BITS-1:0] frac_digits;
	logic exp_negative;
	logic [EXP_BITS-1:0] exp_value;
	logic overflow;

	char_item_t  pending_chars[$];
	num_fields_t parsed_numbers[$];

	// in-bench parse state
	scan_phase_t                scan_ph = SCAN_WS;
	logic                       scan_neg = 1'b0;
	logic [SIG_BITS-1:0]        scan_sig = '0;
	logic [FRAC_COUNT_BITS-1:0] scan_frac = '0;
	logic                       scan_eneg = 1'b0;
	logic [EXP_BITS-1:0]        scan_exp = '0;
	logic                       scan_sat = 1'b0;

	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	logic tx_burst = 1'b0;
	logic rx_burst = 1'b0;
	int mismatches = 0;
	int chars_taken = 0;
	int strings_queued = 0;
	int numbers_checked = 0;
	int ovf_seen = 0;
	int exp_sat_seen = 0;
	int frac_sat_seen = 0;

	scientific_decimal_text_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.last_char    (last_char),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.negative     (negative),
		.significand  (significand),
		.frac_digits  (frac_digits),
		.exp_negative (exp_negative),
		.exp_value    (exp_value),
		.overflow     (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_dec(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_exp_mark(logic [7:0] c);
		return c == CH_E_LO || c == CH_E_UP;
	endfunction

	task automatic take_sig_digit(logic [7:0] c);
		logic [SIG_BITS-1:0] top;
		logic [SIG_BITS-1:0] d;
		top = '1;
		d = SIG_BITS'(c - CH_ZERO);
		if (scan_sat || scan_sig > (top - d) / SIG_BITS'(10)) begin
			scan_sig = top;
			scan_sat = 1'b1;
		end else begin
			scan_sig = scan_sig * SIG_BITS'(10) + d;
		end
	endtask

	task automatic take_exp_digit(logic [7:0] c);
		int unsigned v;
		v = int'(scan_exp) * 10 + int'(c - CH_ZERO);
		scan_exp = (v > EXP_MAX) ? EXP_BITS'(EXP_MAX) : EXP_BITS'(v);
	endtask

	task automatic advance_parse(logic [7:0] c, logic last);
		num_fields_t nf;
		case (scan_ph)
			SCAN_WS: begin
				if (is_ws(c)) begin
				end else if (c == CH_MINUS || c == CH_PLUS) begin
					scan_neg = (c == CH_MINUS);
					scan_ph = SCAN_INT;
				end else if (is_dec(c)) begin
					take_sig_digit(c);
					scan_ph = SCAN_INT;
				end else if (c == CH_POINT) begin
					scan_ph = SCAN_FRAC;
				end else if (is_exp_mark(c)) begin
					scan_ph = SCAN_ESIGN;
				end else begin
					scan_ph = SCAN_DONE;
				end
			end
			SCAN_INT: begin
				if (is_dec(c)) take_sig_digit(c);
				else if (c == CH_POINT) scan_ph = SCAN_FRAC;
				else if (is_exp_mark(c)) scan_ph = SCAN_ESIGN;
				else scan_ph = SCAN_DONE;
			end
			SCAN_FRAC: begin
				if (is_dec(c)) begin
					take_sig_digit(c);
					if (scan_frac != '1) scan_frac = scan_frac + 1'b1;
				end else if (is_exp_mark(c)) begin
					scan_ph = SCAN_ESIGN;
				end else begin
					scan_ph = SCAN_DONE;
				end
			end
			SCAN_ESIGN: begin
				if (c == CH_MINUS || c == CH_PLUS) begin
					scan_eneg = (c == CH_MINUS);
					scan_ph = SCAN_EDIG;
				end else if (is_dec(c)) begin
					take_exp_digit(c);
					scan_ph = SCAN_EDIG;
				end else begin
					scan_ph = SCAN_DONE;
				end
			end
			SCAN_EDIG: begin
				if (is_dec(c)) take_exp_digit(c);
				else scan_ph = SCAN_DONE;
			end
			default: scan_ph = SCAN_DONE;
		endcase
		if (last) begin
			nf.neg = scan_neg;
			nf.sig = scan_sig;
			nf.frac = scan_frac;
			nf.eneg = scan_eneg;
			nf.eval = scan_exp;
			nf.ovf = scan_sat;
			parsed_numbers.push_back(nf);
			scan_ph = SCAN_WS;
			scan_neg = 1'b0;
			scan_sig = '0;
			scan_frac = '0;
			scan_eneg = 1'b0;
			scan_exp = '0;
			scan_sat = 1'b0;
		end
	endtask

	task automatic push_char(logic [7:0] c, logic last, logic quiet);
		char_item_t it;
		if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
		it.code = c;
		it.last = last;
		it.gap = (quiet || tx_burst) ? 0 : $urandom_range(0, 18);
		pending_chars.push_back(it);
		if (last) strings_queued++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == s.len() - 1, 1'b0);
	endtask

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_sign();
		return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
	endfunction

	// returns the number of characters queued
	task automatic queue_random_text(output int n_chars);
		logic [7:0] txt[$];
		int k;
		if ($urandom_range(0, 9) < 7) begin
			k = $urandom_range(0, 3);
			repeat (k) txt.push_back($urandom_range(0, 1) ? CH_SPACE :
				CH_TAB + 8'($urandom_range(0, 4)));
			if ($urandom_range(0, 2) != 0) txt.push_back(rand_sign());
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 26) : $urandom_range(0, 5);
			repeat (k) txt.push_back(rand_digit());
			if ($urandom_range(0, 2) != 0) begin
				txt.push_back(CH_POINT);
				repeat ($urandom_range(0, 6)) txt.push_back(rand_digit());
			end
			if ($urandom_range(0, 1)) begin
				txt.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
				if ($urandom_range(0, 2) != 0) txt.push_back(rand_sign());
				repeat ($urandom_range(0, 6)) txt.push_back(rand_digit());
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
			if (txt.size() > 0 && $urandom_range(0, 7) == 0)
				txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
		end else begin
			k = $urandom_range(1, 8);
			repeat (k) begin
				case ($urandom_range(0, 4))
					0: txt.push_back(rand_digit());
					1: txt.push_back(rand_sign());
					2: txt.push_back($urandom_range(0, 1) ? CH_POINT : CH_E_UP);
					default: txt.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
		if (txt.size() == 0) txt.push_back(8'($urandom_range(0, 255)));
		foreach (txt[i]) push_char(txt[i], i == txt.size() - 1, 1'b0);
		n_chars = txt.size();
	endtask

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin : tx_proc
		char_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= 8'h00;
			last_char <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				advance_parse(char_code, last_char);
				chars_taken++;
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_chars.size() > 0) begin
					if (tx_wait < pending_chars[0].gap) begin
						tx_wait <= tx_wait + 1;
						in_valid <= 1'b0;
					end else begin
						it = pending_chars.pop_front();
						char_code <= it.code;
						last_char <= it.last;
						in_valid <= 1'b1;
						tx_wait <= 0;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : rx_proc
		num_fields_t nf;
		int unsigned nw;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait <= 0;
		end else if (out_valid && out_ready) begin
			if (parsed_numbers.size() == 0) begin
				$display("%0t: result with no expected item, significand %0d",
					$time, significand);
				mismatches++;
			end else begin
				nf = parsed_numbers.pop_front();
				check_field("negative", nf.neg, negative);
				check_field("significand", nf.sig, significand);
				check_field("frac_digits", nf.frac, frac_digits);
				check_field("exp_negative", nf.eneg, exp_negative);
				check_field("exp_value", nf.eval, exp_value);
				check_field("overflow", nf.ovf, overflow);
				if (nf.ovf) ovf_seen++;
				if (nf.eval == EXP_MAX) exp_sat_seen++;
				if (nf.frac == '1) frac_sat_seen++;
			end
			numbers_checked++;
			if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
			// long hold-off so the block backs up into its input
			if (numbers_checked % 50 == 20) nw = 400;
			else nw = rx_burst ? 0 : $urandom_range(0, 18);
			rx_wait <= nw;
			out_ready <= (nw == 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin : stim
		int rand_chars;
		int n;
		logic [7:0] c;
		rand_chars = 0;

		push_text(" \t-1.5e-3");
		push_text("\v+.5E+12");
		push_text("e5");
		push_text(".");
		push_text("-");
		push_text("1+2");
		push_char(8'h00, 1'b1, 1'b0);
		push_char(rand_digit(), 1'b0, 1'b0);
		push_char(8'h78, 1'b0, 1'b0);
		push_char(8'hFF, 1'b1, 1'b0);

		push_text("18446744073709551615");
		push_text("18446744073709551616");
		push_text("1.8446744073709551615e99999");
		while (rand_chars < 1100) begin
			queue_random_text(n);
			rand_chars += n;
			if (rand_chars >= 550 && rand_chars - n < 550) begin
				// long fraction drives the significand into saturation
				push_char(CH_ZERO + 8'd1, 1'b0, 1'b1);
				push_char(CH_POINT, 1'b0, 1'b1);
				for (int i = 0; i < 30; i++) begin
					c = rand_digit();
					push_char(c, 1'b0, 1'b1);
				end
				push_char(CH_E_LO, 1'b0, 1'b1);
				push_char(CH_MINUS, 1'b0, 1'b1);
				push_char(CH_ZERO + 8'd7, 1'b1, 1'b1);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() > 0 || in_valid) @(posedge clk);
		while (parsed_numbers.size() > 0) @(posedge clk);
		repeat (12) @(posedge clk);

		if (parsed_numbers.size() > 0) begin
			$display("%0t: %0d expected results never arrived", $time, parsed_numbers.size());
			mismatches++;
		end
		$display("Parsed %0d strings from %0d characters: %0d checked, %0d mismatches",
			strings_queued, chars_taken, numbers_checked, mismatches);
		$display("Saturation hits: significand %0d, exponent %0d, fraction count %0d",
			ovf_seen, exp_sat_seen, frac_sat_seen);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### scientific_decimal_text_parser.f
hdl/sdtp_pkg.sv
hdl/sdtp_front.sv
hdl/sdtp_queue.sv
hdl/sdtp_back.sv
hdl/scientific_decimal_text_parser.sv
tb/tb_top.sv
